// ----- src/apu_pkg.sv -----
// Shared types and constants for the sampler packet unpacker.
// No dependencies; imported by every module of the block.
package apu_pkg;

  // Highest channel number plus one; mask bits at or above it are ignored
  localparam int CHANNELS = 16;
  localparam logic [15:0] CHAN_LIMIT = 16'((33'd1 << CHANNELS) - 33'd1);

  // Input operation codes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Sample formats (low two bits of the header field)
  localparam logic [1:0] FMT_2BIT  = 2'd0;
  localparam logic [1:0] FMT_4BIT  = 2'd1;
  localparam logic [1:0] FMT_8BIT  = 2'd2;
  localparam logic [1:0] FMT_12BIT = 2'd3;

  // Twelve-bit group phase
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // Work queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified work entry
  typedef struct packed {
    logic             hdr;        // header status entry
    logic [1:0]       cnt;        // samples minus one
    logic [31:0]      idx;        // packet index
    logic [6:0]       lost;
    logic             restarted;
    logic             dropped;
    logic [15:0]      mask;       // channel mask (header entries)
    logic [3:0][11:0] vals;       // samples, element 0 first
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- src/adc_packet_unpacker_top.sv -----
// Top level of the sampler packet unpacker: front, work queue, back.
// Depends on apu_pkg, apu_front, apu_queue, apu_back.
//
//   channel   handshake            payload
//   input     in_valid/in_ready    op, sequence_byte, channel_mask,
//                                  sample_format, data_byte
//   result    out_valid/out_ready  kind, packet_index, lost_packets, restarted,
//                                  dropped, sample_value, channel_number, last
//
// The front takes one item per cycle while the four-entry work queue has room.
// The back sends one result per cycle from its output register while results are taken;
// a byte yields four samples in two-bit format, two in four-bit, one in eight-bit, three
// twelve-bit bytes yield two, a header one. Items pass a queue slot, then the output register.
// Synchronous reset clears sequence tracking, the queue and the output valid.
// Result stalls fill the queue; the input then stalls until an entry drains.
module adc_packet_unpacker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  sequence_byte,
  input  logic [15:0] channel_mask,
  input  logic [2:0]  sample_format,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [31:0] packet_index,
  output logic [6:0]  lost_packets,
  output logic        restarted,
  output logic        dropped,
  output logic [11:0] sample_value,
  output logic [3:0]  channel_number,
  output logic        last
);
  import apu_pkg::*;

  logic      q_push;
  logic      q_pop;
  entry_t    q_in;
  entry_t    q_head;
  q_status_t q_status;

  apu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .sequence_byte (sequence_byte),
    .channel_mask  (channel_mask),
    .sample_format (sample_format),
    .data_byte     (data_byte),
    .q_status      (q_status),
    .push          (q_push),
    .push_entry    (q_in)
  );

  apu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  apu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .q_status       (q_status),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .packet_index   (packet_index),
    .lost_packets   (lost_packets),
    .restarted      (restarted),
    .dropped        (dropped),
    .sample_value   (sample_value),
    .channel_number (channel_number),
    .last           (last)
  );

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("work queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("work queue pop while empty");

  // A header status is always the only result of its transaction
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_HEADER) |-> last && (sample_value == 12'd0))
    else $error("header result without last");

endmodule

// ----- src/apu_front.sv -----
// Front end: accepts items, tracks sequence and packet index, unpacks bytes.
// Depends on apu_pkg; pushes entries into apu_queue.
module apu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [7:0]        sequence_byte,
  input  logic [15:0]       channel_mask,
  input  logic [2:0]        sample_format,
  input  logic [7:0]        data_byte,
  input  apu_pkg::q_status_t q_status,
  output logic              push,
  output apu_pkg::entry_t   push_entry
);
  import apu_pkg::*;

  logic        seen_header, seen_header_next;
  logic [6:0]  last_sequence, last_sequence_next;
  logic [31:0] packet_counter, packet_counter_next;
  logic [1:0]  active_format, active_format_next;
  logic        payload_dropped, payload_dropped_next;
  logic [1:0]  group_phase, group_phase_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [3:0]  held_nibble, held_nibble_next;

  logic        accept;
  logic        restart;
  logic [6:0]  lost;
  logic [15:0] mask;
  logic        emit;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Classification and state update
  always_comb begin
    seen_header_next     = seen_header;
    last_sequence_next   = last_sequence;
    packet_counter_next  = packet_counter;
    active_format_next   = active_format;
    payload_dropped_next = payload_dropped;
    group_phase_next     = group_phase;
    held_byte_next       = held_byte;
    held_nibble_next     = held_nibble;
    emit                 = 1'b0;

    restart = !seen_header || sequence_byte[7];
    lost    = restart ? 7'd0 : (sequence_byte[6:0] - last_sequence - 7'd1);
    mask    = channel_mask & CHAN_LIMIT;

    push_entry           = '0;
    push_entry.idx       = packet_counter;

    if (op == OP_HEADER) begin
      emit                 = 1'b1;
      seen_header_next     = 1'b1;
      last_sequence_next   = sequence_byte[6:0];
      packet_counter_next  = restart ? 32'd0 : packet_counter + {25'd0, lost} + 32'd1;
      active_format_next   = sample_format[1:0];
      payload_dropped_next = (mask == 16'd0) || sample_format[2];
      group_phase_next     = PH_FIRST;
      held_byte_next       = 8'd0;
      held_nibble_next     = 4'd0;
      push_entry.hdr       = 1'b1;
      push_entry.idx       = packet_counter_next;
      push_entry.lost      = lost;
      push_entry.restarted = restart;
      push_entry.dropped   = payload_dropped_next;
      push_entry.mask      = mask;
    end else if (!payload_dropped) begin
      unique case (active_format)
        FMT_2BIT: begin
          emit               = 1'b1;
          push_entry.cnt     = 2'd3;
          push_entry.vals[0] = {data_byte[7:6], 10'd0};
          push_entry.vals[1] = {data_byte[5:4], 10'd0};
          push_entry.vals[2] = {data_byte[3:2], 10'd0};
          push_entry.vals[3] = {data_byte[1:0], 10'd0};
        end
        FMT_4BIT: begin
          emit               = 1'b1;
          push_entry.cnt     = 2'd1;
          push_entry.vals[0] = {data_byte[7:4], 8'd0};
          push_entry.vals[1] = {data_byte[3:0], 8'd0};
        end
        FMT_8BIT: begin
          emit               = 1'b1;
          push_entry.vals[0] = {data_byte, 4'd0};
        end
        default: begin
          // twelve-bit packed groups of three bytes
          priority if (group_phase == PH_FIRST) begin
            held_byte_next   = data_byte;
            group_phase_next = PH_SECOND;
          end else if (group_phase == PH_SECOND) begin
            emit               = 1'b1;
            push_entry.vals[0] = {held_byte, data_byte[7:4]};
            held_nibble_next   = data_byte[3:0];
            group_phase_next   = PH_THIRD;
          end else begin
            emit               = 1'b1;
            push_entry.vals[0] = {data_byte, held_nibble};
            group_phase_next   = PH_FIRST;
          end
        end
      endcase
    end
  end

  assign push = accept && emit;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_header     <= 1'b0;
      last_sequence   <= 7'd0;
      packet_counter  <= 32'd0;
      active_format   <= FMT_2BIT;
      payload_dropped <= 1'b1;
      group_phase     <= PH_FIRST;
      held_byte       <= 8'd0;
      held_nibble     <= 4'd0;
    end else if (accept) begin
      seen_header     <= seen_header_next;
      last_sequence   <= last_sequence_next;
      packet_counter  <= packet_counter_next;
      active_format   <= active_format_next;
      payload_dropped <= payload_dropped_next;
      group_phase     <= group_phase_next;
      held_byte       <= held_byte_next;
      held_nibble     <= held_nibble_next;
    end
  end

endmodule

// ----- src/apu_queue.sv -----
// Short register queue of work entries between front and back.
// Depends on apu_pkg.
module apu_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  apu_pkg::entry_t    push_entry,
  input  logic               pop,
  output apu_pkg::entry_t    head,
  output apu_pkg::q_status_t status
);
  import apu_pkg::*;

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (QAW+1)'(QDEPTH));

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/apu_back.sv -----
// Back end: expands queue entries into results, tags channels, holds output.
// Depends on apu_pkg; reads the head of apu_queue.
module apu_back (
  input  logic               clk,
  input  logic               rst,
  input  apu_pkg::entry_t    head,
  input  apu_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [31:0]        packet_index,
  output logic [6:0]         lost_packets,
  output logic               restarted,
  output logic               dropped,
  output logic [11:0]        sample_value,
  output logic [3:0]         channel_number,
  output logic               last
);
  import apu_pkg::*;

  logic [1:0]  pos;
  logic [15:0] full_mask;
  logic [15:0] rem_mask;
  logic [15:0] rem_cleared;
  logic [3:0]  low_ch;
  logic        load;
  logic        take;
  logic        final_one;

  assign load      = !out_valid || out_ready;
  assign take      = load && !q_status.empty;
  assign final_one = head.hdr || (pos == head.cnt);
  assign pop       = take && final_one;

  // Lowest channel still pending in this mask rotation
  always_comb begin
    low_ch = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (rem_mask[i]) begin
        low_ch = 4'(i);
      end
    end
  end

  assign rem_cleared = rem_mask & (rem_mask - 16'd1);

  // Control: output valid, position in entry, channel rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 2'd0;
      full_mask <= 16'd0;
      rem_mask  <= 16'd0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        pos       <= final_one ? 2'd0 : pos + 2'd1;
        if (head.hdr) begin
          full_mask <= head.mask;
          rem_mask  <= head.mask;
        end else begin
          rem_mask <= (rem_cleared == 16'd0) ? full_mask : rem_cleared;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (take) begin
      packet_index <= head.idx;
      last         <= final_one;
      if (head.hdr) begin
        kind           <= KIND_HEADER;
        lost_packets   <= head.lost;
        restarted      <= head.restarted;
        dropped        <= head.dropped;
        sample_value   <= 12'd0;
        channel_number <= 4'd0;
      end else begin
        kind           <= KIND_SAMPLE;
        lost_packets   <= 7'd0;
        restarted      <= 1'b0;
        dropped        <= 1'b0;
        sample_value   <= head.vals[pos];
        channel_number <= low_ch;
      end
    end
  end

endmodule
